[hw/rtl/ptg_pkg.sv]
package ptg_pkg;

    // Field and register widths
    localparam int InW      = 15;
    localparam int OffW     = 15;
    localparam int CfgW     = 15;
    localparam int CfgIdxW  = 3;
    localparam int DegW     = 9;
    localparam int CoordW   = InW + 1;
    localparam int MagW     = CoordW;
    localparam int FracBits = 16;

    // Root pipeline: radicand is (x^2 + y^2) * 2^32, root has 32 bits
    localparam int SqW        = 2 * MagW;
    localparam int RootW      = SqW;
    localparam int RemW       = RootW + 2;
    localparam int TrialW     = RemW + 3;
    localparam int SqrtStages = RootW;

    // CORDIC datapath
    localparam int CordW        = 36;
    localparam int AngW         = 26;
    localparam int PosW         = 28;
    localparam int CordicStages = 16;
    localparam int StageLimit   = 24;
    localparam int NumStages    = (CordicStages > StageLimit) ? StageLimit : CordicStages;
    localparam logic signed [AngW-1:0] Deg90 = AngW'(90 * 65536);

    // Decoupling queue
    localparam int QueueDepth = 4;
    localparam int QueuePtrW  = $clog2(QueueDepth);
    localparam int QueueCntW  = $clog2(QueueDepth + 1);

    // Requests the block can hold: front, queue, two entry stages, root, CORDIC, output
    localparam int Capacity = 1 + QueueDepth + 2 + SqrtStages + NumStages + 1;
    localparam int CapW     = $clog2(Capacity + 1);

    localparam logic [DegW-1:0] TiltCenter = DegW'(180);

    // Register reset values
    localparam logic signed [OffW-1:0] XOffsetReset = '0;
    localparam logic signed [OffW-1:0] YOffsetReset = '0;
    localparam logic signed [OffW-1:0] ZOffsetReset = -15'sd175;
    localparam logic [DegW-1:0] PanCenterReset = DegW'(180);
    localparam logic [DegW-1:0] PanMinReset    = DegW'(90);
    localparam logic [DegW-1:0] PanMaxReset    = DegW'(270);
    localparam logic [DegW-1:0] TiltMinReset   = DegW'(50);
    localparam logic [DegW-1:0] TiltMaxReset   = DegW'(270);

    typedef enum logic [CfgIdxW-1:0] {
        RegXOffset   = 3'd0,
        RegYOffset   = 3'd1,
        RegZOffset   = 3'd2,
        RegPanCenter = 3'd3,
        RegPanMin    = 3'd4,
        RegPanMax    = 3'd5,
        RegTiltMin   = 3'd6,
        RegTiltMax   = 3'd7
    } ptg_reg_e;

    typedef struct packed {
        logic signed [OffW-1:0] x;
        logic signed [OffW-1:0] y;
        logic signed [OffW-1:0] z;
    } ptg_offsets_t;

    typedef struct packed {
        logic [DegW-1:0] pan_center;
        logic [DegW-1:0] pan_min;
        logic [DegW-1:0] pan_max;
        logic [DegW-1:0] tilt_min;
        logic [DegW-1:0] tilt_max;
    } ptg_limits_t;

    // Classified request as it leaves the front end
    typedef struct packed {
        logic [MagW-1:0] ax;
        logic [MagW-1:0] ay;
        logic [MagW-1:0] az;
        logic            x_neg;
        logic            y_pos;
        logic            z_pos;
        logic            pan_zero;
        logic            tilt_zero;
    } ptg_item_t;

    // Side bits that ride along the CORDIC stages
    typedef struct packed {
        logic y_pos;
        logic z_pos;
        logic pan_zero;
        logic tilt_zero;
    } ptg_flags_t;

    // atan(2^-i) in degrees, 16 fraction bits
    function automatic logic signed [AngW-1:0] atan_deg(input int unsigned idx);
        case (idx)
            0:       atan_deg = AngW'(2949120);
            1:       atan_deg = AngW'(1740967);
            2:       atan_deg = AngW'(919879);
            3:       atan_deg = AngW'(466945);
            4:       atan_deg = AngW'(234379);
            5:       atan_deg = AngW'(117304);
            6:       atan_deg = AngW'(58666);
            7:       atan_deg = AngW'(29335);
            8:       atan_deg = AngW'(14668);
            9:       atan_deg = AngW'(7334);
            10:      atan_deg = AngW'(3667);
            11:      atan_deg = AngW'(1833);
            12:      atan_deg = AngW'(917);
            13:      atan_deg = AngW'(458);
            14:      atan_deg = AngW'(229);
            15:      atan_deg = AngW'(115);
            16:      atan_deg = AngW'(57);
            17:      atan_deg = AngW'(29);
            18:      atan_deg = AngW'(14);
            19:      atan_deg = AngW'(7);
            20:      atan_deg = AngW'(4);
            21:      atan_deg = AngW'(2);
            22:      atan_deg = AngW'(1);
            default: atan_deg = '0;
        endcase
    endfunction

endpackage

[hw/rtl/ptg_in_if.sv]
interface ptg_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [ptg_pkg::InW-1:0]    target_x;
    logic signed [ptg_pkg::InW-1:0]    target_y;
    logic signed [ptg_pkg::InW-1:0]    target_z;

    modport source (output valid, output target_x, output target_y, output target_z,
                    input ready);
    modport sink   (input valid, input target_x, input target_y, input target_z,
                    output ready);
endinterface

[hw/rtl/ptg_out_if.sv]
interface ptg_out_if;
    logic                       valid;
    logic                       ready;
    logic [ptg_pkg::DegW-1:0]   pan_position;
    logic [ptg_pkg::DegW-1:0]   tilt_position;

    modport source (output valid, output pan_position, output tilt_position, input ready);
    modport sink   (input valid, input pan_position, input tilt_position, output ready);
endinterface

[hw/rtl/pan_tilt_gaze_angle.sv]
// Channel  Dir  Fields                                   Handshake
// target   in   target_x, target_y, target_z (15b s)     valid/ready
// aim      out  pan_position, tilt_position (9b u)       valid/ready
// cfg      in   cfg_index (3b), cfg_data (15b)           cfg_we, no wait
//
// One request per cycle sustained when the output side is free. Requests pass
// through the front register, the queue, the entry stages, the 32-stage
// square-root pipeline, the CORDIC stages and the output register.
// Reset clears all control state and loads the register defaults; no clearing pass.
// aim.ready low freezes the back pipeline; the four-entry queue keeps taking
// requests until it and the front register are full, then target.ready drops.
module pan_tilt_gaze_angle (
    input  logic                          clk,
    input  logic                          rst_n,
    ptg_in_if.sink                        target,
    ptg_out_if.source                     aim,
    input  logic                          cfg_we,
    input  logic [ptg_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [ptg_pkg::CfgW-1:0]      cfg_data
);

    ptg_pkg::ptg_offsets_t  offsets_reg;
    ptg_pkg::ptg_offsets_t  offsets_next;
    ptg_pkg::ptg_limits_t   limits_reg;
    ptg_pkg::ptg_limits_t   limits_next;

    ptg_pkg::ptg_item_t     f_item;
    logic                   f_valid;
    logic                   f_ready;
    ptg_pkg::ptg_item_t     q_item;
    logic                   q_valid;
    logic                   q_ready;

    // Configuration register file
    always_comb
    begin
        offsets_next = offsets_reg;
        limits_next  = limits_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                ptg_pkg::RegXOffset:   offsets_next.x = cfg_data;
                ptg_pkg::RegYOffset:   offsets_next.y = cfg_data;
                ptg_pkg::RegZOffset:   offsets_next.z = cfg_data;
                ptg_pkg::RegPanCenter: limits_next.pan_center = cfg_data[ptg_pkg::DegW-1:0];
                ptg_pkg::RegPanMin:    limits_next.pan_min    = cfg_data[ptg_pkg::DegW-1:0];
                ptg_pkg::RegPanMax:    limits_next.pan_max    = cfg_data[ptg_pkg::DegW-1:0];
                ptg_pkg::RegTiltMin:   limits_next.tilt_min   = cfg_data[ptg_pkg::DegW-1:0];
                ptg_pkg::RegTiltMax:   limits_next.tilt_max   = cfg_data[ptg_pkg::DegW-1:0];
                default:               offsets_next = offsets_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offsets_reg.x         <= ptg_pkg::XOffsetReset;
            offsets_reg.y         <= ptg_pkg::YOffsetReset;
            offsets_reg.z         <= ptg_pkg::ZOffsetReset;
            limits_reg.pan_center <= ptg_pkg::PanCenterReset;
            limits_reg.pan_min    <= ptg_pkg::PanMinReset;
            limits_reg.pan_max    <= ptg_pkg::PanMaxReset;
            limits_reg.tilt_min   <= ptg_pkg::TiltMinReset;
            limits_reg.tilt_max   <= ptg_pkg::TiltMaxReset;
        end
        else
        begin
            offsets_reg <= offsets_next;
            limits_reg  <= limits_next;
        end
    end

    ptg_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .target     (target),
        .offsets    (offsets_reg),
        .item       (f_item),
        .item_valid (f_valid),
        .item_ready (f_ready)
    );

    ptg_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_item  (f_item),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .rd_item  (q_item),
        .rd_valid (q_valid),
        .rd_ready (q_ready)
    );

    ptg_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (q_item),
        .item_valid (q_valid),
        .item_ready (q_ready),
        .limits     (limits_reg),
        .aim        (aim)
    );

endmodule

[hw/rtl/ptg_front.sv]
module ptg_front (
    input  logic                   clk,
    input  logic                   rst_n,
    ptg_in_if.sink                 target,
    input  ptg_pkg::ptg_offsets_t  offsets,
    output ptg_pkg::ptg_item_t     item,
    output logic                   item_valid,
    input  logic                   item_ready
);

    logic                               acc;
    logic signed [ptg_pkg::CoordW-1:0]  x;
    logic signed [ptg_pkg::CoordW-1:0]  y;
    logic signed [ptg_pkg::CoordW-1:0]  z;
    ptg_pkg::ptg_item_t                 cls;
    ptg_pkg::ptg_item_t                 item_reg;
    logic                               vld_reg;
    logic                               vld_next;

    // Add camera offsets
    assign x = {target.target_x[ptg_pkg::InW-1], target.target_x}
             + {offsets.x[ptg_pkg::OffW-1], offsets.x};
    assign y = {target.target_y[ptg_pkg::InW-1], target.target_y}
             + {offsets.y[ptg_pkg::OffW-1], offsets.y};
    assign z = {target.target_z[ptg_pkg::InW-1], target.target_z}
             + {offsets.z[ptg_pkg::OffW-1], offsets.z};

    // Magnitudes, signs and the zero-vector cases
    always_comb
    begin
        cls.ax        = x[ptg_pkg::CoordW-1] ? ptg_pkg::MagW'(-x) : ptg_pkg::MagW'(x);
        cls.ay        = y[ptg_pkg::CoordW-1] ? ptg_pkg::MagW'(-y) : ptg_pkg::MagW'(y);
        cls.az        = z[ptg_pkg::CoordW-1] ? ptg_pkg::MagW'(-z) : ptg_pkg::MagW'(z);
        cls.x_neg     = x[ptg_pkg::CoordW-1];
        cls.y_pos     = !y[ptg_pkg::CoordW-1] && (y != '0);
        cls.z_pos     = !z[ptg_pkg::CoordW-1] && (z != '0);
        cls.pan_zero  = (x == '0) && (y == '0);
        cls.tilt_zero = (x == '0) && (y == '0) && (z == '0);
    end

    // One-deep holding register in front of the queue
    assign target.ready = !vld_reg || item_ready;
    assign acc          = target.valid && target.ready;

    always_comb
    begin
        vld_next = vld_reg;
        if (acc)
        begin
            vld_next = 1'b1;
        end
        else if (item_ready)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            item_reg <= cls;
        end
    end

    assign item       = item_reg;
    assign item_valid = vld_reg;

endmodule

[hw/rtl/ptg_fifo.sv]
module ptg_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  ptg_pkg::ptg_item_t  wr_item,
    input  logic                wr_valid,
    output logic                wr_ready,
    output ptg_pkg::ptg_item_t  rd_item,
    output logic                rd_valid,
    input  logic                rd_ready
);

    ptg_pkg::ptg_item_t                 mem_reg [ptg_pkg::QueueDepth];
    logic [ptg_pkg::QueuePtrW-1:0]      wr_ptr_reg;
    logic [ptg_pkg::QueuePtrW-1:0]      wr_ptr_next;
    logic [ptg_pkg::QueuePtrW-1:0]      rd_ptr_reg;
    logic [ptg_pkg::QueuePtrW-1:0]      rd_ptr_next;
    logic [ptg_pkg::QueueCntW-1:0]      count_reg;
    logic [ptg_pkg::QueueCntW-1:0]      count_next;
    logic                               push;
    logic                               pop;

    assign wr_ready = count_reg != ptg_pkg::QueueCntW'(ptg_pkg::QueueDepth);
    assign rd_valid = count_reg != '0;
    assign rd_item  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // Pointers and fill count
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + ptg_pkg::QueuePtrW'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + ptg_pkg::QueuePtrW'(1) : rd_ptr_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + ptg_pkg::QueueCntW'(1);
            2'b01:   count_next = count_reg - ptg_pkg::QueueCntW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

[hw/rtl/ptg_back.sv]
module ptg_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ptg_pkg::ptg_item_t    item,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  ptg_pkg::ptg_limits_t  limits,
    ptg_out_if.source             aim
);

    // Center +/- angle, clamped to [lo, hi], truncated to whole degrees
    function automatic logic [ptg_pkg::DegW-1:0] place(
        input logic [ptg_pkg::DegW-1:0]        center,
        input logic signed [ptg_pkg::AngW-1:0] angle,
        input logic                            positive,
        input logic [ptg_pkg::DegW-1:0]        lo,
        input logic [ptg_pkg::DegW-1:0]        hi
    );
        logic signed [ptg_pkg::PosW-1:0] ang_ext;
        logic signed [ptg_pkg::PosW-1:0] base;
        logic signed [ptg_pkg::PosW-1:0] lo_q;
        logic signed [ptg_pkg::PosW-1:0] hi_q;
        logic signed [ptg_pkg::PosW-1:0] pos;
        ang_ext = {{(ptg_pkg::PosW - ptg_pkg::AngW){angle[ptg_pkg::AngW-1]}}, angle};
        base = {{(ptg_pkg::PosW - ptg_pkg::DegW - ptg_pkg::FracBits){1'b0}}, center,
                {ptg_pkg::FracBits{1'b0}}};
        lo_q = {{(ptg_pkg::PosW - ptg_pkg::DegW - ptg_pkg::FracBits){1'b0}}, lo,
                {ptg_pkg::FracBits{1'b0}}};
        hi_q = {{(ptg_pkg::PosW - ptg_pkg::DegW - ptg_pkg::FracBits){1'b0}}, hi,
                {ptg_pkg::FracBits{1'b0}}};
        pos  = positive ? base + ang_ext : base - ang_ext;
        if (pos < lo_q)
        begin
            place = lo;
        end
        else if (pos > hi_q)
        begin
            place = hi;
        end
        else
        begin
            place = pos[ptg_pkg::FracBits +: ptg_pkg::DegW];
        end
    endfunction

    localparam int LastSq = ptg_pkg::SqrtStages - 1;
    localparam int LastCd = ptg_pkg::NumStages - 1;

    logic                              adv;
    logic                              out_vld_reg;
    logic                              out_vld_next;
    logic [ptg_pkg::DegW-1:0]          pan_reg;
    logic [ptg_pkg::DegW-1:0]          pan_next;
    logic [ptg_pkg::DegW-1:0]          tilt_reg;
    logic [ptg_pkg::DegW-1:0]          tilt_next;

    // Entry stages: squares, then their sum
    logic                              s0_vld_reg;
    ptg_pkg::ptg_item_t                s0_item_reg;
    logic [ptg_pkg::SqW-1:0]           s0_xx_reg;
    logic [ptg_pkg::SqW-1:0]           s0_yy_reg;
    logic [ptg_pkg::SqW-1:0]           ax_ext;
    logic [ptg_pkg::SqW-1:0]           ay_ext;
    logic                              s1_vld_reg;
    ptg_pkg::ptg_item_t                s1_item_reg;
    logic [ptg_pkg::SqW-1:0]           s1_sum_reg;

    // Root pipeline, one result bit per stage
    logic [ptg_pkg::SqrtStages-1:0]    sr_vld_reg;
    ptg_pkg::ptg_item_t                sr_item_reg [ptg_pkg::SqrtStages];
    logic [ptg_pkg::RemW-1:0]          sr_rem_reg  [ptg_pkg::SqrtStages];
    logic [ptg_pkg::RootW-1:0]         sr_root_reg [ptg_pkg::SqrtStages];
    logic [ptg_pkg::SqW-1:0]           sr_bits_reg [ptg_pkg::SqrtStages];

    // CORDIC pipeline, pan and tilt side by side
    logic [ptg_pkg::NumStages-1:0]     cd_vld_reg;
    ptg_pkg::ptg_flags_t               cd_flags_reg [ptg_pkg::NumStages];
    logic signed [ptg_pkg::CordW-1:0]  px_reg [ptg_pkg::NumStages];
    logic signed [ptg_pkg::CordW-1:0]  py_reg [ptg_pkg::NumStages];
    logic signed [ptg_pkg::AngW-1:0]   pa_reg [ptg_pkg::NumStages];
    logic signed [ptg_pkg::CordW-1:0]  tx_reg [ptg_pkg::NumStages];
    logic signed [ptg_pkg::CordW-1:0]  ty_reg [ptg_pkg::NumStages];
    logic signed [ptg_pkg::AngW-1:0]   ta_reg [ptg_pkg::NumStages];

    // Whole pipeline moves when the output register can take a result
    assign adv        = !out_vld_reg || aim.ready;
    assign item_ready = adv;

    assign ax_ext = ptg_pkg::SqW'(item.ax);
    assign ay_ext = ptg_pkg::SqW'(item.ay);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg <= 1'b0;
            s1_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s0_vld_reg <= item_valid;
            s1_vld_reg <= s0_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_item_reg <= item;
            s0_xx_reg   <= ax_ext * ax_ext;
            s0_yy_reg   <= ay_ext * ay_ext;
            s1_item_reg <= s0_item_reg;
            s1_sum_reg  <= s0_xx_reg + s0_yy_reg;
        end
    end

    // Restoring square root of sum * 2^32
    for (genvar k = 0; k < ptg_pkg::SqrtStages; k++)
    begin : g_sqrt
        logic                          vld_in;
        ptg_pkg::ptg_item_t            item_in;
        logic [ptg_pkg::RemW-1:0]      rem_in;
        logic [ptg_pkg::RootW-1:0]     root_in;
        logic [ptg_pkg::SqW-1:0]       bits_in;
        logic [1:0]                    pair;
        logic [ptg_pkg::TrialW-1:0]    trial;
        logic                          fits;
        logic [ptg_pkg::RemW-1:0]      rem_next;
        logic [ptg_pkg::RootW-1:0]     root_next;
        logic [ptg_pkg::SqW-1:0]       bits_next;

        if (k == 0)
        begin : g_first
            assign vld_in  = s1_vld_reg;
            assign item_in = s1_item_reg;
            assign rem_in  = '0;
            assign root_in = '0;
            assign bits_in = s1_sum_reg;
        end
        else
        begin : g_rest
            assign vld_in  = sr_vld_reg[k-1];
            assign item_in = sr_item_reg[k-1];
            assign rem_in  = sr_rem_reg[k-1];
            assign root_in = sr_root_reg[k-1];
            assign bits_in = sr_bits_reg[k-1];
        end

        assign pair      = bits_in[ptg_pkg::SqW-1 -: 2];
        assign bits_next = {bits_in[ptg_pkg::SqW-3:0], 2'b00};
        assign trial     = {1'b0, rem_in, pair} - ptg_pkg::TrialW'({root_in, 2'b01});
        assign fits      = !trial[ptg_pkg::TrialW-1];
        assign rem_next  = fits ? trial[ptg_pkg::RemW-1:0] : {rem_in[ptg_pkg::RemW-3:0], pair};
        assign root_next = {root_in[ptg_pkg::RootW-2:0], fits};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sr_vld_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                sr_vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sr_item_reg[k] <= item_in;
                sr_rem_reg[k]  <= rem_next;
                sr_root_reg[k] <= root_next;
                sr_bits_reg[k] <= bits_next;
            end
        end
    end

    // Vectoring CORDIC stages
    for (genvar i = 0; i < ptg_pkg::NumStages; i++)
    begin : g_cordic
        localparam logic signed [ptg_pkg::AngW-1:0] StepAngle = ptg_pkg::atan_deg(i);

        logic                              vld_in;
        ptg_pkg::ptg_flags_t               flags_in;
        logic signed [ptg_pkg::CordW-1:0]  px_in;
        logic signed [ptg_pkg::CordW-1:0]  py_in;
        logic signed [ptg_pkg::AngW-1:0]   pa_in;
        logic signed [ptg_pkg::CordW-1:0]  tx_in;
        logic signed [ptg_pkg::CordW-1:0]  ty_in;
        logic signed [ptg_pkg::AngW-1:0]   ta_in;
        logic signed [ptg_pkg::CordW-1:0]  px_next;
        logic signed [ptg_pkg::CordW-1:0]  py_next;
        logic signed [ptg_pkg::AngW-1:0]   pa_next;
        logic signed [ptg_pkg::CordW-1:0]  tx_next;
        logic signed [ptg_pkg::CordW-1:0]  ty_next;
        logic signed [ptg_pkg::AngW-1:0]   ta_next;

        if (i == 0)
        begin : g_first
            logic [ptg_pkg::MagW-1:0] pan_x;
            logic [ptg_pkg::MagW-1:0] pan_y;
            ptg_pkg::ptg_item_t       src;

            assign src    = sr_item_reg[LastSq];
            assign vld_in = sr_vld_reg[LastSq];
            assign flags_in.y_pos     = src.y_pos;
            assign flags_in.z_pos     = src.z_pos;
            assign flags_in.pan_zero  = src.pan_zero;
            assign flags_in.tilt_zero = src.tilt_zero;
            // Left half plane: pre-rotate by 90 degrees
            assign pan_x = src.x_neg ? src.ay : src.ax;
            assign pan_y = src.x_neg ? src.ax : src.ay;
            assign px_in = {{(ptg_pkg::CordW - ptg_pkg::MagW - ptg_pkg::FracBits){1'b0}},
                            pan_x, {ptg_pkg::FracBits{1'b0}}};
            assign py_in = {{(ptg_pkg::CordW - ptg_pkg::MagW - ptg_pkg::FracBits){1'b0}},
                            pan_y, {ptg_pkg::FracBits{1'b0}}};
            assign pa_in = src.x_neg ? ptg_pkg::Deg90 : '0;
            assign tx_in = {{(ptg_pkg::CordW - ptg_pkg::RootW){1'b0}}, sr_root_reg[LastSq]};
            assign ty_in = {{(ptg_pkg::CordW - ptg_pkg::MagW - ptg_pkg::FracBits){1'b0}},
                            src.az, {ptg_pkg::FracBits{1'b0}}};
            assign ta_in = '0;
        end
        else
        begin : g_rest
            assign vld_in   = cd_vld_reg[i-1];
            assign flags_in = cd_flags_reg[i-1];
            assign px_in    = px_reg[i-1];
            assign py_in    = py_reg[i-1];
            assign pa_in    = pa_reg[i-1];
            assign tx_in    = tx_reg[i-1];
            assign ty_in    = ty_reg[i-1];
            assign ta_in    = ta_reg[i-1];
        end

        // Rotate toward the x axis; arithmetic shift floors
        always_comb
        begin
            if (!py_in[ptg_pkg::CordW-1])
            begin
                px_next = px_in + (py_in >>> i);
                py_next = py_in - (px_in >>> i);
                pa_next = pa_in + StepAngle;
            end
            else
            begin
                px_next = px_in - (py_in >>> i);
                py_next = py_in + (px_in >>> i);
                pa_next = pa_in - StepAngle;
            end
            if (!ty_in[ptg_pkg::CordW-1])
            begin
                tx_next = tx_in + (ty_in >>> i);
                ty_next = ty_in - (tx_in >>> i);
                ta_next = ta_in + StepAngle;
            end
            else
            begin
                tx_next = tx_in - (ty_in >>> i);
                ty_next = ty_in + (tx_in >>> i);
                ta_next = ta_in - StepAngle;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                cd_vld_reg[i] <= 1'b0;
            end
            else if (adv)
            begin
                cd_vld_reg[i] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                cd_flags_reg[i] <= flags_in;
                px_reg[i]       <= px_next;
                py_reg[i]       <= py_next;
                pa_reg[i]       <= pa_next;
                tx_reg[i]       <= tx_next;
                ty_reg[i]       <= ty_next;
                ta_reg[i]       <= ta_next;
            end
        end
    end

    // Placement and clamping into the output register
    always_comb
    begin
        out_vld_next = cd_vld_reg[LastCd];
        pan_next  = place(limits.pan_center,
                          cd_flags_reg[LastCd].pan_zero ? '0 : pa_reg[LastCd],
                          cd_flags_reg[LastCd].y_pos, limits.pan_min, limits.pan_max);
        tilt_next = place(ptg_pkg::TiltCenter,
                          cd_flags_reg[LastCd].tilt_zero ? '0 : ta_reg[LastCd],
                          cd_flags_reg[LastCd].z_pos, limits.tilt_min, limits.tilt_max);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pan_reg  <= pan_next;
            tilt_reg <= tilt_next;
        end
    end

    assign aim.valid         = out_vld_reg;
    assign aim.pan_position  = pan_reg;
    assign aim.tilt_position = tilt_reg;

endmodule

[hw/rtl/ptg_checker.sv]
module ptg_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       target_valid,
    input logic                       target_ready,
    input logic                       aim_valid,
    input logic                       aim_ready,
    input logic [ptg_pkg::DegW-1:0]   pan_position,
    input logic [ptg_pkg::DegW-1:0]   tilt_position
);

    logic                        in_acc;
    logic                        out_acc;
    logic [ptg_pkg::CapW-1:0]    pending_reg;
    logic [ptg_pkg::CapW-1:0]    pending_next;

    assign in_acc  = target_valid && target_ready;
    assign out_acc = aim_valid && aim_ready;

    // Requests taken but not yet answered
    always_comb
    begin
        case ({in_acc, out_acc})
            2'b10:   pending_next = pending_reg + ptg_pkg::CapW'(1);
            2'b01:   pending_next = pending_reg - ptg_pkg::CapW'(1);
            default: pending_next = pending_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // A stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        aim_valid && !aim_ready |=> aim_valid && $stable(pan_position)
                                    && $stable(tilt_position))
        else $error("result changed while stalled");

    // No result without an outstanding request
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc |-> pending_reg != '0)
        else $error("result without request");

    // An empty block always takes a request
    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg == '0 |-> target_ready)
        else $error("idle block not ready");

    // Storage never holds more than the pipeline can
    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= ptg_pkg::CapW'(ptg_pkg::Capacity))
        else $error("more requests in flight than storage");

endmodule

bind pan_tilt_gaze_angle ptg_checker u_ptg_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .target_valid  (target.valid),
    .target_ready  (target.ready),
    .aim_valid     (aim.valid),
    .aim_ready     (aim.ready),
    .pan_position  (aim.pan_position),
    .tilt_position (aim.tilt_position)
);

[test/pan_tilt_gaze_angle_tb.sv]
`timescale 1ns / 1ps

module pan_tilt_gaze_angle_tb;

    localparam int  ONE_Q       = 65536;
    localparam int  TILT_MID    = int'(ptg_pkg::TiltCenter);
    localparam int  ITER_REQ    = ptg_pkg::CordicStages;
    localparam int  ITER_CAP    = ptg_pkg::StageLimit;
    localparam int  ITERS       = (ITER_REQ > ITER_CAP) ? ITER_CAP : ITER_REQ;
    localparam int  LATENCY     = 36 + ITERS;
    localparam int  HOLD_CYCLES = 400;
    localparam int  CYCLE_LIMIT = 400000;
    localparam int  FRAC        = ptg_pkg::FracBits;
    localparam int  DEG_W       = ptg_pkg::DegW;

    typedef struct packed {
        logic signed [ptg_pkg::InW-1:0] x;
        logic signed [ptg_pkg::InW-1:0] y;
        logic signed [ptg_pkg::InW-1:0] z;
    } point_t;

    typedef struct packed {
        logic [ptg_pkg::DegW-1:0] pan;
        logic [ptg_pkg::DegW-1:0] tilt;
    } aim_t;

    // atan(2^-i) in degrees, 16 fraction bits
    longint atan_q16 [ITER_CAP] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [ptg_pkg::CfgIdxW-1:0] cfg_index;
    logic [ptg_pkg::CfgW-1:0] cfg_data;

    ptg_in_if  target_ch ();
    ptg_out_if aim_ch ();

    pan_tilt_gaze_angle i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .target    (target_ch),
        .aim       (aim_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the register file
    logic signed [ptg_pkg::OffW-1:0] x_off   = 15'sd0;
    logic signed [ptg_pkg::OffW-1:0] y_off   = 15'sd0;
    logic signed [ptg_pkg::OffW-1:0] z_off   = -15'sd175;
    logic [ptg_pkg::DegW-1:0]        pan_ctr = 9'd180;
    logic [ptg_pkg::DegW-1:0]        pan_lo  = 9'd90;
    logic [ptg_pkg::DegW-1:0]        pan_hi  = 9'd270;
    logic [ptg_pkg::DegW-1:0]        tilt_lo = 9'd50;
    logic [ptg_pkg::DegW-1:0]        tilt_hi = 9'd270;

    point_t point_queue [$];
    aim_t   aim_expected [$];
    aim_t   aim_want;

    bit  point_taken;
    bit  hold_start;
    bit  hold_rx;
    int  send_idle_pct;
    int  recv_stall_pct;
    int  cycle_count;
    int  error_count;
    int  points_sent;
    int  aims_checked;
    int  settings_used;

    // Vectoring rotation: drives vy to zero, returns accumulated angle
    function automatic longint atan_vector(longint vx, longint vy, longint start);
        longint acc;
        longint dx;
        longint dy;
        acc = start;
        for (int i = 0; i < ITERS; i++)
        begin
            dx = vy >>> i;
            dy = vx >>> i;
            if (vy >= 0)
            begin
                vx  = vx + dx;
                vy  = vy - dy;
                acc = acc + atan_q16[i];
            end
            else
            begin
                vx  = vx - dx;
                vy  = vy + dy;
                acc = acc - atan_q16[i];
            end
        end
        return acc;
    endfunction

    // Center +/- angle, clamped, then truncated to whole degrees
    function automatic logic [DEG_W-1:0] place_deg(longint center, longint ang, bit up,
                                                   logic [DEG_W-1:0] lo,
                                                   logic [DEG_W-1:0] hi);
        longint pos;
        pos = center * ONE_Q + (up ? ang : -ang);
        if (pos < longint'(lo) * ONE_Q)
            return lo;
        else if (pos > longint'(hi) * ONE_Q)
            return hi;
        else
            return pos[FRAC+DEG_W-1:FRAC];
    endfunction

    function automatic aim_t aim_predict(point_t p);
        longint x;
        longint y;
        longint z;
        longint ay;
        longint az;
        longint pan_ang;
        longint tilt_ang;
        longint unsigned rad;
        longint unsigned root;
        longint unsigned bit_v;
        aim_t res;
        x  = longint'(p.x) + longint'(x_off);
        y  = longint'(p.y) + longint'(y_off);
        z  = longint'(p.z) + longint'(z_off);
        ay = (y < 0) ? -y : y;
        az = (z < 0) ? -z : z;
        pan_ang  = 0;
        tilt_ang = 0;

        // Pan: left half plane is pre-rotated by 90 degrees
        if (x != 0 || y != 0)
        begin
            if (x >= 0)
                pan_ang = atan_vector(x * ONE_Q, ay * ONE_Q, 0);
            else
                pan_ang = atan_vector(ay * ONE_Q, -x * ONE_Q, 90 * ONE_Q);
        end

        // Tilt: exact integer root of (x^2 + y^2) * 2^32
        if (x != 0 || y != 0 || z != 0)
        begin
            rad   = longint'(x * x + y * y) << 32;
            root  = 0;
            bit_v = 64'h4000_0000_0000_0000;
            while (bit_v > rad)
                bit_v = bit_v >> 2;
            while (bit_v != 0)
            begin
                if (rad >= root + bit_v)
                begin
                    rad  = rad - (root + bit_v);
                    root = (root >> 1) + bit_v;
                end
                else
                begin
                    root = root >> 1;
                end
                bit_v = bit_v >> 2;
            end
            tilt_ang = atan_vector(longint'(root), az * ONE_Q, 0);
        end

        res.pan  = place_deg(longint'(pan_ctr), pan_ang, y > 0, pan_lo, pan_hi);
        res.tilt = place_deg(TILT_MID, tilt_ang, z > 0, tilt_lo, tilt_hi);
        return res;
    endfunction

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Request driver: holds an offered request until it is taken
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            target_ch.valid <= 1'b0;
        end
        else if (!target_ch.valid || point_taken)
        begin
            if (point_queue.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                target_ch.valid    <= 1'b1;
                target_ch.target_x <= point_queue[0].x;
                target_ch.target_y <= point_queue[0].y;
                target_ch.target_z <= point_queue[0].z;
            end
            else
            begin
                target_ch.valid <= 1'b0;
            end
        end
        point_taken = 1'b0;
    end

    // Result side back-pressure
    always @(negedge clk)
    begin
        if (hold_rx)
            aim_ch.ready <= 1'b0;
        else
            aim_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Long receiver hold-off while requests keep coming
    initial
    begin : rx_hold
        hold_rx = 1'b0;
        wait (hold_start);
        hold_rx = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rx = 1'b0;
    end

    // Monitor: predicts on accepted requests, checks accepted results
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d results still pending", $time, aim_expected.size());
            $display("RESULT: ERROR");
            $finish;
        end
        else if (rst_n)
        begin
            if (target_ch.valid && target_ch.ready)
            begin
                aim_expected.push_back(aim_predict(point_queue[0]));
                point_queue.pop_front();
                point_taken = 1'b1;
                points_sent++;
            end
            if (aim_ch.valid && aim_ch.ready)
            begin
                if (aim_expected.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected result: expected none, got pan %0d tilt %0d",
                             $time, aim_ch.pan_position, aim_ch.tilt_position);
                end
                else
                begin
                    aim_want = aim_expected.pop_front();
                    aims_checked++;
                    if (aim_ch.pan_position !== aim_want.pan)
                    begin
                        error_count++;
                        $display("%0t: pan_position mismatch: expected %0d, got %0d",
                                 $time, aim_want.pan, aim_ch.pan_position);
                    end
                    if (aim_ch.tilt_position !== aim_want.tilt)
                    begin
                        error_count++;
                        $display("%0t: tilt_position mismatch: expected %0d, got %0d",
                                 $time, aim_want.tilt, aim_ch.tilt_position);
                    end
                end
            end
        end
    end

    task automatic reg_write(ptg_pkg::ptg_reg_e idx, logic [ptg_pkg::CfgW-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            ptg_pkg::RegXOffset:   x_off   = data;
            ptg_pkg::RegYOffset:   y_off   = data;
            ptg_pkg::RegZOffset:   z_off   = data;
            ptg_pkg::RegPanCenter: pan_ctr = data[DEG_W-1:0];
            ptg_pkg::RegPanMin:    pan_lo  = data[DEG_W-1:0];
            ptg_pkg::RegPanMax:    pan_hi  = data[DEG_W-1:0];
            ptg_pkg::RegTiltMin:   tilt_lo = data[DEG_W-1:0];
            ptg_pkg::RegTiltMax:   tilt_hi = data[DEG_W-1:0];
            default:               ;
        endcase
    endtask

    // Degree registers get random junk in the unused upper data bits
    function automatic logic [ptg_pkg::CfgW-1:0] deg_word(int v);
        logic [ptg_pkg::CfgW-1:0] w;
        w = 15'($urandom);
        w[DEG_W-1:0] = 9'(v);
        return w;
    endfunction

    task automatic program_regs(int xo, int yo, int zo, int pc, int pl, int ph,
                                int tl, int th);
        reg_write(ptg_pkg::RegXOffset, 15'(xo));
        reg_write(ptg_pkg::RegYOffset, 15'(yo));
        reg_write(ptg_pkg::RegZOffset, 15'(zo));
        reg_write(ptg_pkg::RegPanCenter, deg_word(pc));
        reg_write(ptg_pkg::RegPanMin, deg_word(pl));
        reg_write(ptg_pkg::RegPanMax, deg_word(ph));
        reg_write(ptg_pkg::RegTiltMin, deg_word(tl));
        reg_write(ptg_pkg::RegTiltMax, deg_word(th));
        settings_used++;
    endtask

    function automatic int random_offset();
        if ($urandom_range(2) == 0)
            return int'($urandom_range(32767)) - 16384;
        else
            return int'($urandom_range(4000)) - 2000;
    endfunction

    function automatic int random_deg();
        case ($urandom_range(7))
            0:       return 0;
            1:       return 511;
            2:       return int'($urandom_range(511));
            default: return int'($urandom_range(360));
        endcase
    endfunction

    task automatic random_setting();
        int pl;
        int ph;
        int tl;
        int th;
        pl = random_deg();
        ph = random_deg();
        tl = random_deg();
        th = random_deg();
        // Mostly ordered limits, sometimes inverted
        if ($urandom_range(4) != 0 && pl > ph)
        begin
            pl = pl ^ ph;
            ph = pl ^ ph;
            pl = pl ^ ph;
        end
        if ($urandom_range(4) != 0 && tl > th)
        begin
            tl = tl ^ th;
            th = tl ^ th;
            tl = tl ^ th;
        end
        program_regs(random_offset(), random_offset(), random_offset(), random_deg(),
                     pl, ph, tl, th);
    endtask

    task automatic queue_point(int x, int y, int z);
        point_t p;
        p.x = 15'(x);
        p.y = 15'(y);
        p.z = 15'(z);
        point_queue.push_back(p);
    endtask

    // Mix of full-range, near-origin, on-axis and offset-cancelling points
    task automatic queue_random_point();
        point_t p;
        int kind;
        kind = $urandom_range(9);
        p.x = 15'($urandom);
        p.y = 15'($urandom);
        p.z = 15'($urandom);
        if (kind == 6 || kind == 7)
        begin
            p.x = 15'(int'($urandom_range(64)) - 32);
            p.y = 15'(int'($urandom_range(64)) - 32);
            p.z = 15'(int'($urandom_range(64)) - 32);
        end
        else if (kind == 8)
        begin
            if ($urandom_range(1) == 0) p.x = '0;
            if ($urandom_range(1) == 0) p.y = '0;
            if ($urandom_range(2) == 0) p.z = '0;
        end
        else if (kind == 9)
        begin
            p.x = 15'(-int'(x_off));
            p.y = 15'(-int'(y_off));
            if ($urandom_range(1) == 0)
                p.z = 15'(-int'(z_off));
        end
        point_queue.push_back(p);
    endtask

    task automatic set_idle(int mode);
        case (mode)
            0:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            1:
            begin
                send_idle_pct  = 77;
                recv_stall_pct = 0;
            end
            2:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 77;
            end
            default:
            begin
                send_idle_pct  = 29;
                recv_stall_pct = 29;
            end
        endcase
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (point_queue.size() > 0 || aim_expected.size() > 0)
            @(posedge clk);
    endtask

    // Main sequence
    initial
    begin
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        target_ch.valid    = 1'b0;
        target_ch.target_x = '0;
        target_ch.target_y = '0;
        target_ch.target_z = '0;
        aim_ch.ready       = 1'b0;
        hold_start         = 1'b0;
        point_taken        = 1'b0;
        cycle_count        = 0;
        error_count        = 0;
        points_sent        = 0;
        aims_checked       = 0;
        settings_used      = 0;
        set_idle(0);
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // Register defaults after reset
        @(posedge clk);
        queue_point(0, 0, 0);
        queue_point(0, 0, 175);
        queue_point(100, 100, 500);
        queue_point(-100, 0, -500);
        queue_point(16383, -16384, 16383);
        wait_drained();

        // Wide-open limits, no offsets: zero vectors, axes, field extremes
        program_regs(0, 0, 0, 180, 0, 360, 0, 360);
        @(posedge clk);
        queue_point(0, 0, 0);
        queue_point(0, 0, 5);
        queue_point(0, 0, -5);
        queue_point(5, 0, 0);
        queue_point(-5, 0, 0);
        queue_point(0, 5, 0);
        queue_point(0, -5, 0);
        queue_point(16383, 16383, 16383);
        queue_point(-16384, -16384, -16384);
        queue_point(16383, -16384, 0);
        queue_point(-16384, 16383, -1);
        queue_point(1, 1, 1);
        queue_point(-1, -1, -1);
        wait_drained();

        // Largest offsets, pan centered at zero, limits at full pattern
        program_regs(16383, 16383, 16383, 0, 0, 511, 0, 511);
        @(posedge clk);
        queue_point(16383, 16383, 16383);
        queue_point(-16384, -16384, -16384);
        queue_point(-16383, -16383, -16383);
        wait_drained();

        // Smallest offsets with inverted limits
        program_regs(-16384, -16384, -16384, 511, 511, 0, 400, 100);
        @(posedge clk);
        queue_point(-16384, -16384, -16384);
        queue_point(16383, 16383, 16383);
        queue_point(16383, -16384, 16383);
        wait_drained();

        // Receiver holds off long enough that the input side stalls
        program_regs(0, 0, -175, 180, 90, 270, 50, 270);
        set_idle(0);
        @(posedge clk);
        repeat (200) queue_random_point();
        hold_start = 1'b1;
        wait_drained();

        // Random settings, cycling through the idling patterns
        for (int ph = 0; ph < 12; ph++)
        begin
            random_setting();
            set_idle(ph % 4);
            @(posedge clk);
            repeat (70) queue_random_point();
            wait_drained();
        end

        repeat (2 * LATENCY) @(posedge clk);
        $display("Sent %0d target points over %0d register settings, %0d aim results checked",
                 points_sent, settings_used, aims_checked);
        $display("Covered zero vectors, axes, offset extremes, inverted limits and stalls");
        if (error_count == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("%0d mismatches", error_count);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[files.f]
hw/rtl/ptg_pkg.sv
hw/rtl/ptg_in_if.sv
hw/rtl/ptg_out_if.sv
hw/rtl/ptg_front.sv
hw/rtl/ptg_fifo.sv
hw/rtl/ptg_back.sv
hw/rtl/pan_tilt_gaze_angle.sv
hw/rtl/ptg_checker.sv
test/pan_tilt_gaze_angle_tb.sv
